@@ hw/rtl/rsa_mexp_pkg.sv @@
// Shared widths and register index codes for the RSA exponentiation core.
`timescale 1ns / 1ps

package rsa_mexp_pkg;

    // operand and modulus width
    localparam int unsigned W = 31;

    // step counter for one shift-add modular multiply (W steps)
    localparam int unsigned CNT_W = $clog2(W);

    // configuration register index
    localparam int unsigned IDX_W = 2;

    typedef enum logic [IDX_W-1:0] {
        REG_MODULUS     = 2'd0,
        REG_PUBLIC_EXP  = 2'd1,
        REG_PRIVATE_EXP = 2'd2,
        REG_UNUSED      = 2'd3
    } reg_idx_t;

    // smallest modulus the register will hold
    localparam logic [W-1:0] MOD_MIN = W'(2);

    typedef logic [W-1:0] word_t;

endpackage

@@ hw/rtl/rsa_modular_exponentiation_core.sv @@
// RSA modular exponentiation core: right-to-left square-and-multiply.
//
// Usage:
//   Requests arrive on in_valid/in_stall with func (0 = public exponent,
//   1 = private exponent) and a 31-bit value. The result value^exp mod n
//   leaves on out_valid/out_stall. A transfer happens on a clock edge with
//   valid high and stall low. The user must write modulus and exponents on
//   the cfg port (cfg_valid/cfg_ready, cfg_index, cfg_data) only while the
//   core is idle; the core does not enforce this. cfg_ready is always high.
//   A modulus below 2 is stored as 2.
// One shared shift-add modular multiplier retires one multiplier bit per
//   cycle. A request is accepted and its value reduced mod n; then, per
//   exponent bit up to the highest set bit, a check step, a multiply if the
//   bit is set and a squaring (skipped after the top bit); then the result
//   is posted. A zero exponent goes straight from the check to posting.
// The core holds in_stall high while a request is in flight. A finished
//   result sits in an output register; when the receiver stalls, the next
//   request is still accepted and waits before posting until the register
//   frees up. Reset clears the registers to modulus 2, exponents 0.
`timescale 1ns / 1ps

module rsa_modular_exponentiation_core (
    input  logic                               clk,
    input  logic                               rst_n,
    // request channel
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               func,
    input  logic [rsa_mexp_pkg::W-1:0]         value,
    // result channel
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [rsa_mexp_pkg::W-1:0]         result,
    // configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rsa_mexp_pkg::IDX_W-1:0]     cfg_index,
    input  logic [rsa_mexp_pkg::W-1:0]         cfg_data
);

    localparam int unsigned W     = rsa_mexp_pkg::W;
    localparam int unsigned CNT_W = rsa_mexp_pkg::CNT_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_CHECK,
        ST_MUL,
        ST_SQR,
        ST_FINISH
    } state_t;

    // sequencer and datapath registers
    state_t                  state_reg, state_next;
    rsa_mexp_pkg::word_t     mod_reg, mod_next;
    rsa_mexp_pkg::word_t     pub_reg, pub_next;
    rsa_mexp_pkg::word_t     priv_reg, priv_next;
    rsa_mexp_pkg::word_t     exp_reg, exp_next;
    rsa_mexp_pkg::word_t     acc_reg, acc_next;
    rsa_mexp_pkg::word_t     pw_reg, pw_next;
    rsa_mexp_pkg::word_t     ma_reg, ma_next;
    rsa_mexp_pkg::word_t     mb_reg, mb_next;
    rsa_mexp_pkg::word_t     r_reg, r_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    out_valid_reg, out_valid_next;
    rsa_mexp_pkg::word_t     result_reg, result_next;

    // shared multiplier step: r <- (2r + bit*a) mod n, with r, a < n
    logic [W+1:0]            sum_s;
    logic [W+1:0]            mod_x1;
    logic [W+1:0]            mod_x2;
    rsa_mexp_pkg::word_t     step_r;
    logic                    last_step;

    assign sum_s  = {1'b0, r_reg, 1'b0} + (mb_reg[W-1] ? {2'b00, ma_reg} : '0);
    assign mod_x1 = {2'b00, mod_reg};
    assign mod_x2 = {1'b0, mod_reg, 1'b0};

    always_comb
    begin
        if (sum_s >= mod_x2)
        begin
            step_r = W'(sum_s - mod_x2);
        end
        else if (sum_s >= mod_x1)
        begin
            step_r = W'(sum_s - mod_x1);
        end
        else
        begin
            step_r = W'(sum_s);
        end
    end

    assign last_step = (cnt_reg == '0);

    // handshake outputs
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign result    = result_reg;
    assign cfg_ready = 1'b1;

    // sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        mod_next       = mod_reg;
        pub_next       = pub_reg;
        priv_next      = priv_reg;
        exp_next       = exp_reg;
        acc_next       = acc_reg;
        pw_next        = pw_reg;
        ma_next        = ma_reg;
        mb_next        = mb_reg;
        r_next         = r_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        result_next    = result_reg;

        // result taken downstream
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        // configuration writes
        if (cfg_valid && cfg_ready)
        begin
            unique case (rsa_mexp_pkg::reg_idx_t'(cfg_index))
                rsa_mexp_pkg::REG_MODULUS:
                begin
                    mod_next = (cfg_data < rsa_mexp_pkg::MOD_MIN) ?
                               rsa_mexp_pkg::MOD_MIN : cfg_data;
                end
                rsa_mexp_pkg::REG_PUBLIC_EXP:  pub_next  = cfg_data;
                rsa_mexp_pkg::REG_PRIVATE_EXP: priv_next = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    exp_next   = func ? priv_reg : pub_reg;
                    acc_next   = W'(1);
                    // reduce value as 1 * value mod n
                    ma_next    = W'(1);
                    mb_next    = value;
                    r_next     = '0;
                    cnt_next   = CNT_W'(W - 1);
                    state_next = ST_REDUCE;
                end
            end

            ST_REDUCE:
            begin
                r_next   = step_r;
                mb_next  = mb_reg << 1;
                cnt_next = cnt_reg - 1'b1;
                if (last_step)
                begin
                    pw_next    = step_r;
                    state_next = ST_CHECK;
                end
            end

            ST_CHECK:
            begin
                ma_next  = pw_reg;
                r_next   = '0;
                cnt_next = CNT_W'(W - 1);
                if (exp_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
                else if (exp_reg[0])
                begin
                    mb_next    = acc_reg;
                    state_next = ST_MUL;
                end
                else
                begin
                    mb_next    = pw_reg;
                    state_next = ST_SQR;
                end
            end

            ST_MUL:
            begin
                r_next   = step_r;
                mb_next  = mb_reg << 1;
                cnt_next = cnt_reg - 1'b1;
                if (last_step)
                begin
                    acc_next = step_r;
                    if (exp_reg[W-1:1] == '0)
                    begin
                        // top bit done, squaring not needed
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        ma_next    = pw_reg;
                        mb_next    = pw_reg;
                        r_next     = '0;
                        cnt_next   = CNT_W'(W - 1);
                        state_next = ST_SQR;
                    end
                end
            end

            ST_SQR:
            begin
                r_next   = step_r;
                mb_next  = mb_reg << 1;
                cnt_next = cnt_reg - 1'b1;
                if (last_step)
                begin
                    pw_next    = step_r;
                    exp_next   = exp_reg >> 1;
                    state_next = ST_CHECK;
                end
            end

            ST_FINISH:
            begin
                // post once the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    result_next    = acc_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mod_reg       <= rsa_mexp_pkg::MOD_MIN;
            pub_reg       <= '0;
            priv_reg      <= '0;
            exp_reg       <= '0;
            acc_reg       <= '0;
            pw_reg        <= '0;
            ma_reg        <= '0;
            mb_reg        <= '0;
            r_reg         <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            result_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            mod_reg       <= mod_next;
            pub_reg       <= pub_next;
            priv_reg      <= priv_next;
            exp_reg       <= exp_next;
            acc_reg       <= acc_next;
            pw_reg        <= pw_next;
            ma_reg        <= ma_next;
            mb_reg        <= mb_next;
            r_reg         <= r_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            result_reg    <= result_next;
        end
    end

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the RSA modular exponentiation core.
`timescale 1ns / 1ps

module testbench;

    typedef rsa_mexp_pkg::word_t    word_t;
    typedef rsa_mexp_pkg::reg_idx_t reg_idx_t;

    // request operation codes
    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    localparam word_t       WORD_MAX     = '1;
    localparam int unsigned CYCLE_LIMIT  = 8_000_000;
    localparam int unsigned DRAIN_CYCLES = 2100;
    localparam int unsigned HOLD_CYCLES  = 6000;
    localparam int unsigned RAND_PHASES  = 6;
    localparam int unsigned PHASE_REQS   = 45;

    typedef struct {
        logic  op;
        word_t value;
    } request_t;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    logic     in_stall;
    logic     func      = OP_ENCRYPT;
    word_t    value     = '0;
    logic     out_valid;
    logic     out_stall = 1'b0;
    word_t    result;
    logic     cfg_valid = 1'b0;
    logic     cfg_ready;
    reg_idx_t cfg_index = rsa_mexp_pkg::REG_MODULUS;
    word_t    cfg_data  = '0;

    // request source and expected powers
    request_t    pending_reqs[$];
    word_t       expected_powers[$];
    int unsigned queued_cnt   = 0;
    int unsigned accepted_cnt = 0;
    int unsigned results_seen = 0;
    int unsigned fail_count   = 0;
    int unsigned cycle_count  = 0;

    // predictor copy of the key registers
    word_t key_modulus  = rsa_mexp_pkg::MOD_MIN;
    word_t key_pub_exp  = '0;
    word_t key_priv_exp = '0;

    // sender and receiver pacing
    request_t    next_req;
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;
    int unsigned stall_left = 0;
    logic        stall_on   = 1'b0;
    logic        hold_off   = 1'b0;
    word_t       want;

    rsa_modular_exponentiation_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // right-to-left square-and-multiply, 64-bit products
    function automatic word_t power_mod(input word_t base, input word_t expo,
                                        input word_t n);
        logic [63:0] acc;
        logic [63:0] pw;
        logic [63:0] n64;
        word_t       e;
        acc = 64'd1;
        pw  = 64'(base);
        n64 = 64'(n);
        e   = expo;
        while (e != '0)
        begin
            if (e[0])
                acc = (acc * pw) % n64;
            pw = (pw * pw) % n64;
            e  = e >> 1;
        end
        return word_t'(acc);
    endfunction

    // mix of tiny, full-width and extreme exponents
    function automatic word_t pick_exponent();
        case ($urandom_range(0, 4))
            0: return word_t'($urandom_range(0, 40));
            1: return WORD_MAX;
            2: return word_t'(1) << $urandom_range(0, 30);
            default: return word_t'($urandom);
        endcase
    endfunction

    task automatic push_req(input logic op, input word_t v);
        request_t r;
        r.op    = op;
        r.value = v;
        pending_reqs.push_back(r);
        queued_cnt++;
    endtask

    // one register write; starts and ends on a clock edge
    task automatic write_reg(input reg_idx_t idx, input word_t data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_keys(input word_t n, input word_t e_pub, input word_t e_priv);
        write_reg(rsa_mexp_pkg::REG_MODULUS, n);
        write_reg(rsa_mexp_pkg::REG_PUBLIC_EXP, e_pub);
        write_reg(rsa_mexp_pkg::REG_PRIVATE_EXP, e_priv);
    endtask

    // all queued requests accepted and answered
    task automatic wait_idle();
        while (accepted_cnt != queued_cnt || expected_powers.size() != 0)
            @(posedge clk);
    endtask

    // request driver: bursts of random length with random gaps
    always @(posedge clk)
    begin
        if (rst_n && (!in_valid || !in_stall))
        begin
            if (gap_left != 0 || pending_reqs.size() == 0)
            begin
                if (gap_left != 0)
                    gap_left--;
                in_valid <= 1'b0;
            end
            else
            begin
                next_req = pending_reqs.pop_front();
                in_valid <= 1'b1;
                func     <= next_req.op;
                value    <= next_req.value;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(0, 7);
                    case ($urandom_range(0, 3))
                        0: gap_left = 0;
                        3: gap_left = $urandom_range(1, 2100);
                        default: gap_left = $urandom_range(1, 20);
                    endcase
                end
                else
                    burst_left--;
            end
        end
    end

    // result stall pattern: alternating free and stalled runs
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left == 0)
            begin
                stall_on = !stall_on;
                if (stall_on)
                    stall_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2500)
                                                             : $urandom_range(1, 30);
                else
                    stall_left = $urandom_range(1, 3000);
            end
            else
                stall_left--;
            out_stall <= hold_off | stall_on;
        end
    end

    // long receiver hold-off so the core backs up onto its input
    initial
    begin
        wait (results_seen >= 40);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // monitor: register writes, accepted requests, results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    rsa_mexp_pkg::REG_MODULUS:
                        key_modulus = (cfg_data < rsa_mexp_pkg::MOD_MIN) ?
                                      rsa_mexp_pkg::MOD_MIN : cfg_data;
                    rsa_mexp_pkg::REG_PUBLIC_EXP:  key_pub_exp  = cfg_data;
                    rsa_mexp_pkg::REG_PRIVATE_EXP: key_priv_exp = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                expected_powers.push_back(power_mod(value,
                    (func == OP_DECRYPT) ? key_priv_exp : key_pub_exp, key_modulus));
                accepted_cnt++;
            end
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (expected_powers.size() == 0)
                begin
                    $error("unexpected result: result=%0d with no request outstanding", result);
                    fail_count++;
                end
                else
                begin
                    want = expected_powers.pop_front();
                    if (result !== want)
                    begin
                        $error("field result: expected %0d, actual %0d", want, result);
                        fail_count++;
                    end
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // stimulus sequence
    initial
    begin
        word_t n_now;
        word_t n_eff;
        word_t v;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // reset keys: modulus 2, zero exponents give 1
        push_req(OP_ENCRYPT, '0);
        push_req(OP_DECRYPT, WORD_MAX);
        wait_idle();

        // modulus 0 saturates to 2; unused index is ignored
        set_keys('0, WORD_MAX, word_t'(1));
        write_reg(rsa_mexp_pkg::REG_UNUSED, word_t'(12345));
        push_req(OP_ENCRYPT, '0);
        push_req(OP_ENCRYPT, word_t'(1));
        push_req(OP_ENCRYPT, WORD_MAX);
        push_req(OP_DECRYPT, word_t'(3));
        push_req(OP_DECRYPT, WORD_MAX);
        wait_idle();

        // largest modulus, full public exponent, zero private exponent
        set_keys(WORD_MAX, WORD_MAX, '0);
        push_req(OP_ENCRYPT, '0);
        push_req(OP_ENCRYPT, word_t'(1));
        push_req(OP_ENCRYPT, WORD_MAX);
        push_req(OP_ENCRYPT, WORD_MAX - word_t'(1));
        push_req(OP_DECRYPT, word_t'(12345));
        push_req(OP_ENCRYPT, 31'h5555_5555);
        push_req(OP_ENCRYPT, 31'h2AAA_AAAA);
        wait_idle();

        // modulus 1 saturates to 2; top exponent bit alone
        set_keys(word_t'(1), word_t'(65537), word_t'(1) << 30);
        push_req(OP_ENCRYPT, word_t'(3));
        push_req(OP_DECRYPT, word_t'(5));
        push_req(OP_DECRYPT, '0);
        wait_idle();

        // textbook key pair, round trip and value equal to the modulus
        set_keys(word_t'(3233), word_t'(17), word_t'(2753));
        push_req(OP_ENCRYPT, word_t'(65));
        push_req(OP_DECRYPT, word_t'(2790));
        push_req(OP_ENCRYPT, word_t'(3232));
        push_req(OP_DECRYPT, word_t'(3233));
        push_req(OP_ENCRYPT, word_t'(1));

        // random key settings, each with a batch of random requests
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            wait_idle();
            case ($urandom_range(0, 3))
                0: n_now = word_t'($urandom_range(0, 5));
                1: n_now = WORD_MAX - word_t'($urandom_range(0, 3));
                2: n_now = word_t'($urandom_range(2, 65535));
                default: n_now = word_t'($urandom);
            endcase
            n_eff = (n_now < rsa_mexp_pkg::MOD_MIN) ? rsa_mexp_pkg::MOD_MIN : n_now;
            set_keys(n_now, pick_exponent(), pick_exponent());
            if ($urandom_range(0, 1) == 1)
                write_reg(rsa_mexp_pkg::REG_UNUSED, word_t'($urandom));
            for (int k = 0; k < PHASE_REQS; k++)
            begin
                case ($urandom_range(0, 9))
                    0: v = '0;
                    1: v = word_t'(1);
                    2: v = WORD_MAX;
                    3: v = n_eff - word_t'(1);
                    4, 5: v = word_t'($urandom);
                    default: v = word_t'($urandom_range(0, n_eff - 1));
                endcase
                push_req($urandom_range(0, 1) ? OP_DECRYPT : OP_ENCRYPT, v);
            end
        end

        // drain, then watch for stray results
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && expected_powers.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/rsa_mexp_pkg.sv
hw/rtl/rsa_modular_exponentiation_core.sv
sim/testbench.sv
